[rtl/piecewise_cubic_bezier_eval_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise cubic Bezier evaluator
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_CUBIC_BEZIER_EVAL_TOP_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_EVAL_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcbe_pkg.sv]
// ----------------------------------------------------------------------------
// pcbe_pkg
// Shared constants, types and lerp arithmetic of the Bezier evaluator.
// ----------------------------------------------------------------------------
package pcbe_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int COORD_BITS   = 32;
  localparam int NUM_POINTS   = 3 * MAX_SEGMENTS + 1;
  localparam int IDX_BITS     = 6;
  localparam int T_BITS       = 17;
  localparam int FRAC_BITS    = 16;
  localparam int SEG_BITS     = $clog2(MAX_SEGMENTS + 1);
  localparam int A_DEPTH      = MAX_SEGMENTS + 1;
  localparam int BC_DEPTH     = MAX_SEGMENTS;
  localparam int A_IDX_BITS   = $clog2(A_DEPTH);
  localparam int BC_IDX_BITS  = $clog2(BC_DEPTH);
  localparam int PROD_BITS    = COORD_BITS + 1 + FRAC_BITS + 1;
  localparam int PIPE_DEPTH   = 8;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [T_BITS-1:0]   T_ONE = T_BITS'(1 << FRAC_BITS);
  localparam logic [SEG_BITS-1:0] SEG_MAX = SEG_BITS'(MAX_SEGMENTS);
  localparam logic [SEG_BITS-1:0] SEG_COUNT_RESET = SEG_BITS'(1);
  localparam logic [CFG_ADDR_BITS-3:0] REG_SEGMENT_COUNT = '0;

  // Point slot 3q+r lives in bank r at row q.
  localparam logic [1:0] BANK_A = 2'd0;
  localparam logic [1:0] BANK_B = 2'd1;
  localparam logic [1:0] BANK_C = 2'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [2:0][COORD_BITS-1:0] vec3_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] u;
    vec3_t [3:0]          pts;
  } lerp_req_t;

  typedef struct packed {
    logic [A_IDX_BITS-1:0] q;
    logic [1:0]            r;
  } div3_t;

  // idx / 3 by reciprocal multiply, exact for 6-bit values.
  function automatic div3_t div3(input logic [IDX_BITS-1:0] idx);
    logic [2*IDX_BITS:0] prod;
    logic [IDX_BITS-1:0] q;
    logic [IDX_BITS+1:0] back;
    div3_t res;
    prod  = (2*IDX_BITS+1)'(idx) * (2*IDX_BITS+1)'(43);
    q     = prod[IDX_BITS+6:7];
    back  = (IDX_BITS+2)'(q) * (IDX_BITS+2)'(3);
    res.q = A_IDX_BITS'(q);
    res.r = 2'((IDX_BITS+2)'(idx) - back);
    return res;
  endfunction

  // (b - a) * u, full width.
  function automatic logic signed [PROD_BITS-1:0] lerp_mul(input coord_t a, input coord_t b,
                                                           input logic [FRAC_BITS-1:0] u);
    logic signed [COORD_BITS:0] d;
    logic signed [FRAC_BITS:0]  us;
    logic signed [PROD_BITS-1:0] p;
    d  = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
    us = $signed({1'b0, u});
    p  = d * us;
    return p;
  endfunction

  // a + floor(prod / 2^16); the result stays between a and b.
  function automatic coord_t lerp_add(input coord_t a, input logic [PROD_BITS-1:0] prod);
    logic signed [PROD_BITS-FRAC_BITS-1:0] part;
    logic signed [PROD_BITS-FRAC_BITS-1:0] sum;
    part = $signed(prod[PROD_BITS-1:FRAC_BITS]);
    sum  = $signed({{(PROD_BITS-FRAC_BITS-COORD_BITS){a[COORD_BITS-1]}}, a}) + part;
    return sum[COORD_BITS-1:0];
  endfunction

endpackage

[rtl/pcbe_ifs.sv]
// ----------------------------------------------------------------------------
// pcbe stream interfaces
// Valid/ready channels for command beats in and curve point beats out.
// ----------------------------------------------------------------------------
interface pcbe_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [pcbe_pkg::IDX_BITS-1:0]         point_index;
  logic signed [pcbe_pkg::COORD_BITS-1:0] coord_x;
  logic signed [pcbe_pkg::COORD_BITS-1:0] coord_y;
  logic signed [pcbe_pkg::COORD_BITS-1:0] coord_z;
  logic [pcbe_pkg::T_BITS-1:0]           param_t;

  modport source (output valid, command, point_index, coord_x, coord_y, coord_z, param_t,
                  input ready);
  modport sink   (input valid, command, point_index, coord_x, coord_y, coord_z, param_t,
                  output ready);
endinterface

interface pcbe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pcbe_pkg::COORD_BITS-1:0] point_x;
  logic signed [pcbe_pkg::COORD_BITS-1:0] point_y;
  logic signed [pcbe_pkg::COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[rtl/pcbe_casteljau.sv]
// ----------------------------------------------------------------------------
// pcbe_casteljau
// Three de Casteljau lerp levels, each a multiply stage and an add stage,
// with per-stage valid bits and a ready chain; the last stage is the output.
// ----------------------------------------------------------------------------
module pcbe_casteljau (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  pcbe_pkg::lerp_req_t req,
  pcbe_out_if.source          out_if
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  logic [pcbe_pkg::FRAC_BITS-1:0] m1_u_r, a1_u_r, m2_u_r, a2_u_r;
  pcbe_pkg::vec3_t [2:0] m1_a_r;
  logic [2:0][2:0][pcbe_pkg::PROD_BITS-1:0] m1_p_r;
  pcbe_pkg::vec3_t [2:0] a1_r;
  pcbe_pkg::vec3_t [1:0] m2_a_r;
  logic [1:0][2:0][pcbe_pkg::PROD_BITS-1:0] m2_p_r;
  pcbe_pkg::vec3_t [1:0] a2_r;
  pcbe_pkg::vec3_t m3_a_r;
  logic [2:0][pcbe_pkg::PROD_BITS-1:0] m3_p_r;
  pcbe_pkg::vec3_t point_r;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_if.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign req_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= req_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m1_u_r <= req.u;
      for (int j = 0; j < 3; j++) begin
        m1_a_r[j] <= req.pts[j];
        for (int c = 0; c < 3; c++) begin
          m1_p_r[j][c] <= pcbe_pkg::lerp_mul(req.pts[j][c], req.pts[j+1][c], req.u);
        end
      end
    end
    if (rdy[1]) begin
      a1_u_r <= m1_u_r;
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          a1_r[j][c] <= pcbe_pkg::lerp_add(m1_a_r[j][c], m1_p_r[j][c]);
        end
      end
    end
    if (rdy[2]) begin
      m2_u_r <= a1_u_r;
      for (int j = 0; j < 2; j++) begin
        m2_a_r[j] <= a1_r[j];
        for (int c = 0; c < 3; c++) begin
          m2_p_r[j][c] <= pcbe_pkg::lerp_mul(a1_r[j][c], a1_r[j+1][c], a1_u_r);
        end
      end
    end
    if (rdy[3]) begin
      a2_u_r <= m2_u_r;
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          a2_r[j][c] <= pcbe_pkg::lerp_add(m2_a_r[j][c], m2_p_r[j][c]);
        end
      end
    end
    if (rdy[4]) begin
      m3_a_r <= a2_r[0];
      for (int c = 0; c < 3; c++) begin
        m3_p_r[c] <= pcbe_pkg::lerp_mul(a2_r[0][c], a2_r[1][c], a2_u_r);
      end
    end
    if (rdy[5]) begin
      for (int c = 0; c < 3; c++) begin
        point_r[c] <= pcbe_pkg::lerp_add(m3_a_r[c], m3_p_r[c]);
      end
    end
  end

  assign out_if.valid   = v_r[NSTG-1];
  assign out_if.point_x = point_r[0];
  assign out_if.point_y = point_r[1];
  assign out_if.point_z = point_r[2];

endmodule

[rtl/piecewise_cubic_bezier_eval_top.sv]
// ----------------------------------------------------------------------------
// piecewise_cubic_bezier_eval_top
// Composite cubic Bezier evaluator over a banked table of 3-D control points.
// ----------------------------------------------------------------------------
// Takes one beat per clock while no evaluate beat is held up by a stalled
// output. A write beat stores a control point and gives no result; an
// evaluate beat gives its curve point through an input register, the
// registered read of the point table, three lerp levels of a multiply stage
// and an add stage each, the last add stage being the output register.
// Every stage has its own valid bit, so empty stages keep filling while a
// result waits. The table is split into three banks by slot mod 3 so the
// four points of a segment are read in the same cycle. Writes and reads take
// effect in beat order.
module piecewise_cubic_bezier_eval_top (
  input  logic                                clk,
  input  logic                                rst_n,
  pcbe_in_if.sink                             in_if,
  pcbe_out_if.source                          out_if,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pcbe_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [pcbe_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [pcbe_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SB = pcbe_pkg::SEG_BITS;

  // Configuration register
  logic [SB-1:0] seg_count_r;
  logic          cfg_wr;
  logic          cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[pcbe_pkg::CFG_ADDR_BITS-1:2] == pcbe_pkg::REG_SEGMENT_COUNT;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? pcbe_pkg::CFG_DATA_BITS'(seg_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= pcbe_pkg::SEG_COUNT_RESET;
    end else if (cfg_wr && cfg_hit) begin
      seg_count_r <= cfg_pwdata[SB-1:0];
    end
  end

  // Input decode
  logic [SB-1:0]                       n_eff;
  logic [pcbe_pkg::T_BITS-1:0]         t_clamp;
  logic [pcbe_pkg::T_BITS+SB-1:0]      scaled;
  logic                                is_end;
  logic [SB-1:0]                       k_nxt;
  logic [SB-1:0]                       khi_nxt;
  logic [pcbe_pkg::FRAC_BITS-1:0]      u_nxt;
  pcbe_pkg::div3_t                     slot;

  always_comb begin
    if (seg_count_r == '0) begin
      n_eff = SB'(1);
    end else if (seg_count_r > pcbe_pkg::SEG_MAX) begin
      n_eff = pcbe_pkg::SEG_MAX;
    end else begin
      n_eff = seg_count_r;
    end
    t_clamp = (in_if.param_t > pcbe_pkg::T_ONE) ? pcbe_pkg::T_ONE : in_if.param_t;
    scaled  = (pcbe_pkg::T_BITS+SB)'(t_clamp) * (pcbe_pkg::T_BITS+SB)'(n_eff);
    is_end  = (t_clamp == '0) || (t_clamp == pcbe_pkg::T_ONE);
    // End points read one table point and run the lerps at u = 0.
    if (t_clamp == '0) begin
      k_nxt = '0;
    end else if (t_clamp == pcbe_pkg::T_ONE) begin
      k_nxt = n_eff;
    end else begin
      k_nxt = scaled[pcbe_pkg::FRAC_BITS +: SB];
    end
    u_nxt   = is_end ? '0 : scaled[pcbe_pkg::FRAC_BITS-1:0];
    khi_nxt = is_end ? k_nxt : SB'(k_nxt + SB'(1));
    slot    = pcbe_pkg::div3(in_if.point_index);
  end

  // Input stage
  logic                                  s0_v_r;
  logic                                  s0_eval_r;
  logic                                  s0_wr_ok_r;
  logic [1:0]                            s0_bank_r;
  logic [pcbe_pkg::A_IDX_BITS-1:0]       s0_waddr_r;
  pcbe_pkg::vec3_t                       s0_wdata_r;
  logic [SB-1:0]                         s0_k_r;
  logic [SB-1:0]                         s0_khi_r;
  logic [pcbe_pkg::FRAC_BITS-1:0]        s0_u_r;
  logic                                  s0_end_r;
  logic                                  s1_v_r;
  logic                                  rdy0;
  logic                                  rdy1;
  logic                                  core_ready;

  assign rdy1        = !s1_v_r || core_ready;
  assign rdy0        = !s0_v_r || !s0_eval_r || rdy1;
  assign in_if.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy0) begin
      s0_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_eval_r  <= in_if.command == pcbe_pkg::CMD_EVAL;
      s0_wr_ok_r <= in_if.point_index < pcbe_pkg::IDX_BITS'(pcbe_pkg::NUM_POINTS);
      s0_bank_r  <= slot.r;
      s0_waddr_r <= slot.q;
      s0_wdata_r <= {in_if.coord_z, in_if.coord_y, in_if.coord_x};
      s0_k_r     <= k_nxt;
      s0_khi_r   <= khi_nxt;
      s0_u_r     <= u_nxt;
      s0_end_r   <= is_end;
    end
  end

  // Point table: bank A holds slots 3q, bank B 3q+1, bank C 3q+2.
  pcbe_pkg::vec3_t bank_a [pcbe_pkg::A_DEPTH];
  pcbe_pkg::vec3_t bank_b [pcbe_pkg::BC_DEPTH];
  pcbe_pkg::vec3_t bank_c [pcbe_pkg::BC_DEPTH];
  logic            wr_fire;

  assign wr_fire = s0_v_r && !s0_eval_r && s0_wr_ok_r;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      unique case (s0_bank_r)
        pcbe_pkg::BANK_A: bank_a[s0_waddr_r] <= s0_wdata_r;
        pcbe_pkg::BANK_B: bank_b[s0_waddr_r[pcbe_pkg::BC_IDX_BITS-1:0]] <= s0_wdata_r;
        pcbe_pkg::BANK_C: bank_c[s0_waddr_r[pcbe_pkg::BC_IDX_BITS-1:0]] <= s0_wdata_r;
        default: ;
      endcase
    end
  end

  // Table read stage
  logic [pcbe_pkg::FRAC_BITS-1:0] s1_u_r;
  logic                           s1_end_r;
  pcbe_pkg::vec3_t                pa_r, pb_r, pc_r, pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= s0_v_r && s0_eval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_u_r   <= s0_u_r;
      s1_end_r <= s0_end_r;
      pa_r     <= bank_a[s0_k_r];
      pd_r     <= bank_a[s0_khi_r];
      pb_r     <= bank_b[s0_k_r[pcbe_pkg::BC_IDX_BITS-1:0]];
      pc_r     <= bank_c[s0_k_r[pcbe_pkg::BC_IDX_BITS-1:0]];
    end
  end

  // Drop the neighbor points at the curve ends so only the end point counts.
  pcbe_pkg::lerp_req_t req;

  always_comb begin
    req.u      = s1_u_r;
    req.pts[0] = pa_r;
    req.pts[1] = s1_end_r ? '0 : pb_r;
    req.pts[2] = s1_end_r ? '0 : pc_r;
    req.pts[3] = s1_end_r ? '0 : pd_r;
  end

  pcbe_casteljau u_casteljau (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_v_r),
    .req_ready (core_ready),
    .req       (req),
    .out_if    (out_if)
  );

endmodule

[rtl/pcbe_checker.sv]
// ----------------------------------------------------------------------------
// pcbe_checker
// Port-level checks of the Bezier evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_cubic_bezier_eval_top_macros.svh"

module pcbe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pcbe_pkg::COORD_BITS-1:0] out_point_x,
  input logic [pcbe_pkg::COORD_BITS-1:0] out_point_y,
  input logic [pcbe_pkg::COORD_BITS-1:0] out_point_z
);

  localparam int CNT_BITS = $clog2(pcbe_pkg::PIPE_DEPTH + 1) + 1;

  logic [CNT_BITS-1:0] pending_r;
  logic [CNT_BITS-1:0] pending_nxt;
  logic                eval_beat;
  logic                out_beat;

  assign eval_beat = in_valid && in_ready && (in_command == pcbe_pkg::CMD_EVAL);
  assign out_beat  = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (eval_beat && !out_beat) begin
      pending_nxt = CNT_BITS'(pending_r + CNT_BITS'(1));
    end else if (out_beat && !eval_beat) begin
      pending_nxt = CNT_BITS'(pending_r - CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `PCBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z), "stalled result beat changed")
  `PCBE_ASSERT_IMPL(a_ready_flows, out_ready, in_ready, "input stalled while output drains")
  `PCBE_ASSERT_IMPL(a_no_phantom, out_valid, pending_r != '0, "result beat without evaluate beat")
  `PCBE_ASSERT_IMPL(a_depth, 1'b1, pending_r <= CNT_BITS'(pcbe_pkg::PIPE_DEPTH), "more beats in flight than stages")

endmodule

bind piecewise_cubic_bezier_eval_top pcbe_checker u_pcbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_command  (in_if.command),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_point_x (out_if.point_x),
  .out_point_y (out_if.point_y),
  .out_point_z (out_if.point_z)
);
